// ===== rtl/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// No dependencies; used by every module of the block.
package u16u8_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] BOM_UNIT  = 16'hFEFF;
  localparam logic [15:0] HIGH_LO   = 16'hD800;
  localparam logic [15:0] HIGH_HI   = 16'hDBFF;
  localparam logic [15:0] ONE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_LIMIT = 16'h0800;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [7:0]  LEAD_TWO  = 8'hC0;
  localparam logic [7:0]  LEAD_THR  = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR = 8'hF0;
  localparam logic [7:0]  CONT_MARK = 8'h80;

  localparam logic [1:0] CLS_ONE   = 2'd0;
  localparam logic [1:0] CLS_TWO   = 2'd1;
  localparam logic [1:0] CLS_THREE = 2'd2;
  localparam logic [1:0] CLS_HIGH  = 2'd3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        start_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } job_t;

endpackage

// ===== rtl/utf16_to_utf8_encoder_core.sv =====
// UTF-16 to UTF-8 encoder, top level: front end, job queue, back end.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
//
// One 16-bit code unit is taken per cycle while the job queue has room.
// Bytes leave the back end one per cycle while out_ready is high. A unit
// yields one byte for ASCII, two or three for other BMP units, four for a
// surrogate pair (charged to the low unit), none for a held high surrogate
// or a dropped byte-order mark. The byte serialiser sets the sustained
// rate; the queue of QUEUE_DEPTH jobs absorbs bursts. The user must write
// swap_r via cfg_we/cfg_wdata only while idle; the block does not enforce it.
module utf16_to_utf8_encoder_core #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u16u8_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_item
);

  logic            fj_valid, fj_ready;
  u16u8_pkg::job_t fj_job;
  logic            qb_valid, qb_ready;
  u16u8_pkg::job_t qb_job;

  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_job   (fj_job),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_job   (qb_job)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_job     (qb_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/u16u8_front.sv =====
// Front end: byte swap, mark drop, surrogate pairing and byte formation.
// Depends on u16u8_pkg.
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  u16u8_pkg::in_item_t in_item,
  output logic                job_valid,
  input  logic                job_ready,
  output u16u8_pkg::job_t     job
);

  logic       swap_r;
  logic [9:0] pend_bits_r, pend_bits_nxt;
  logic       pend_r, pend_nxt;
  logic [15:0] u;
  logic [20:0] cp;
  logic [1:0]  cls;
  logic        is_bom;
  logic        pend_eff;
  logic        accept;

  assign is_bom   = in_item.start_of_string && (in_item.code_unit == u16u8_pkg::BOM_UNIT);
  assign pend_eff = pend_r && !in_item.start_of_string;
  assign u        = swap_r ? {in_item.code_unit[7:0], in_item.code_unit[15:8]}
                           : in_item.code_unit;
  assign cp       = {1'b0, pend_bits_r, u[9:0]} + u16u8_pkg::SUPP_BASE;

  always_comb begin
    if (u < u16u8_pkg::ONE_LIMIT) begin
      cls = u16u8_pkg::CLS_ONE;
    end else if (u < u16u8_pkg::TWO_LIMIT) begin
      cls = u16u8_pkg::CLS_TWO;
    end else if (u >= u16u8_pkg::HIGH_LO && u <= u16u8_pkg::HIGH_HI) begin
      cls = u16u8_pkg::CLS_HIGH;
    end else begin
      cls = u16u8_pkg::CLS_THREE;
    end
  end

  always_comb begin
    job.bytes    = '0;
    job.last_idx = 2'd0;
    job_valid    = 1'b0;
    if (pend_eff) begin
      job.bytes[0] = u16u8_pkg::LEAD_FOUR | {5'd0, cp[20:18]};
      job.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, cp[17:12]};
      job.bytes[2] = u16u8_pkg::CONT_MARK | {2'd0, cp[11:6]};
      job.bytes[3] = u16u8_pkg::CONT_MARK | {2'd0, cp[5:0]};
      job.last_idx = 2'd3;
      job_valid    = in_valid;
    end else begin
      unique case (cls)
        u16u8_pkg::CLS_ONE: begin
          job.bytes[0] = u[7:0];
          job_valid    = in_valid && !is_bom;
        end
        u16u8_pkg::CLS_TWO: begin
          job.bytes[0] = u16u8_pkg::LEAD_TWO | {3'd0, u[10:6]};
          job.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, u[5:0]};
          job.last_idx = 2'd1;
          job_valid    = in_valid && !is_bom;
        end
        u16u8_pkg::CLS_THREE: begin
          job.bytes[0] = u16u8_pkg::LEAD_THR | {4'd0, u[15:12]};
          job.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, u[11:6]};
          job.bytes[2] = u16u8_pkg::CONT_MARK | {2'd0, u[5:0]};
          job.last_idx = 2'd2;
          job_valid    = in_valid && !is_bom;
        end
        u16u8_pkg::CLS_HIGH: begin
          job_valid = 1'b0;
        end
        default: begin
          job_valid = 1'b0;
        end
      endcase
    end
  end

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pend_nxt      = pend_r;
    pend_bits_nxt = pend_bits_r;
    if (accept) begin
      if (is_bom || pend_eff) begin
        pend_nxt      = 1'b0;
        pend_bits_nxt = '0;
      end else if (cls == u16u8_pkg::CLS_HIGH) begin
        pend_nxt      = 1'b1;
        pend_bits_nxt = u[9:0];
      end else begin
        pend_nxt      = 1'b0;
        pend_bits_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r      <= 1'b0;
      pend_r      <= 1'b0;
      pend_bits_r <= '0;
    end else begin
      if (cfg_we) begin
        swap_r <= cfg_wdata;
      end
      pend_r      <= pend_nxt;
      pend_bits_r <= pend_bits_nxt;
    end
  end

endmodule

// ===== rtl/u16u8_queue.sv =====
// Short job queue between front and back ends, held in registers.
// Depends on u16u8_pkg.
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  u16u8_pkg::job_t wr_job,
  output logic            rd_valid,
  input  logic            rd_ready,
  output u16u8_pkg::job_t rd_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u16u8_pkg::job_t   slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/u16u8_back.sv =====
// Back end: serialises one queued job into bytes, one per cycle while out_ready is high.
// Depends on u16u8_pkg.
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  u16u8_pkg::job_t      q_job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_item
);

  u16u8_pkg::job_t job_r;
  logic            busy_r, busy_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic            out_acc, at_last, load;

  assign out_valid            = busy_r;
  assign at_last              = (idx_r == job_r.last_idx);
  assign out_item.out_byte    = job_r.bytes[idx_r];
  assign out_item.last_of_run = at_last;
  assign out_acc              = out_valid && out_ready;
  assign q_ready              = !busy_r || (out_acc && at_last);
  assign load                 = q_valid && q_ready;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (out_acc) begin
      if (at_last) begin
        busy_nxt = 1'b0;
        idx_nxt  = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= job_r.last_idx))
    else $error("byte index past end of job");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && idx_r == 2'd0))
    else $error("loaded job does not start at first byte");

  a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && at_last && !q_valid) |=> !busy_r)
    else $error("back end busy after last byte with empty queue");
`endif

endmodule

// ===== tb/tb_u16u8_sb_pkg.sv =====
// Scoreboard for the UTF-16 to UTF-8 encoder testbench: predicts the UTF-8
// bytes of every accepted code unit and checks each byte that leaves the block.
// Depends on u16u8_pkg for the item types and encoding constants.
package tb_u16u8_sb_pkg;
  import u16u8_pkg::*;

  class utf8_scoreboard;
    bit          swap_units;
    bit [9:0]    held_high;
    bit          high_held;
    out_item_t   bytes_due[$];
    int unsigned errors;

    function new();
      swap_units = 1'b0;
      held_high  = '0;
      high_held  = 1'b0;
      errors     = 0;
    endfunction

    function void set_swap(bit value);
      swap_units = value;
    endfunction

    function int unsigned pending();
      return bytes_due.size();
    endfunction

    function void add_byte(logic [7:0] value, logic last);
      out_item_t due;
      due.out_byte    = value;
      due.last_of_run = last;
      bytes_due = {bytes_due, due};
    endfunction

    function void note_unit(in_item_t item);
      logic [15:0] u;
      logic [20:0] cp;
      if (item.start_of_string) begin
        high_held = 1'b0;
        held_high = '0;
        if (item.code_unit == BOM_UNIT) return;
      end
      u = swap_units ? {item.code_unit[7:0], item.code_unit[15:8]} : item.code_unit;
      if (high_held) begin
        cp = {1'b0, held_high, u[9:0]} + SUPP_BASE;
        high_held = 1'b0;
        held_high = '0;
        add_byte(LEAD_FOUR | {5'd0, cp[20:18]}, 1'b0);
        add_byte(CONT_MARK | {2'd0, cp[17:12]}, 1'b0);
        add_byte(CONT_MARK | {2'd0, cp[11:6]}, 1'b0);
        add_byte(CONT_MARK | {2'd0, cp[5:0]}, 1'b1);
      end else if (u < ONE_LIMIT) begin
        add_byte(u[7:0], 1'b1);
      end else if (u < TWO_LIMIT) begin
        add_byte(LEAD_TWO | {3'd0, u[10:6]}, 1'b0);
        add_byte(CONT_MARK | {2'd0, u[5:0]}, 1'b1);
      end else if (u >= HIGH_LO && u <= HIGH_HI) begin
        held_high = u[9:0];
        high_held = 1'b1;
      end else begin
        add_byte(LEAD_THR | {4'd0, u[15:12]}, 1'b0);
        add_byte(CONT_MARK | {2'd0, u[11:6]}, 1'b0);
        add_byte(CONT_MARK | {2'd0, u[5:0]}, 1'b1);
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (bytes_due.size() == 0) begin
        $error("out_byte: expected none, actual 0x%02h", got.out_byte);
        errors++;
        return;
      end
      want = bytes_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected 0x%02h, actual 0x%02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, actual %0b", want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_utf16_to_utf8_encoder_core.sv =====
// Top-level testbench for utf16_to_utf8_encoder_core: directed and random
// UTF-16 strings in both byte orders, with random stalls on both channels.
// Depends on u16u8_pkg, tb_u16u8_sb_pkg and the encoder RTL.
module tb_utf16_to_utf8_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::*;
  import tb_u16u8_sb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_UNITS   = 52;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  utf8_scoreboard sb = new();
  bit             no_gaps    = 1'b0;
  int unsigned    units_sent = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    ready_run  = 0;
  int unsigned    stall_run  = 0;

  utf16_to_utf8_encoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_byte(out_item);
      if (ready_run > 0) begin
        ready_run--;
        out_ready <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_ready <= 1'b0;
      end else begin
        ready_run = $urandom_range(12, 1);
        stall_run = pick_gap();
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_unit(input logic [15:0] unit, input logic sos);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= {unit, sos};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_unit(in_item);
    if (!(sos && unit == BOM_UNIT)) units_sent++;
  endtask

  task automatic push_host(input logic [15:0] u, input logic sos);
    push_unit(sb.swap_units ? {u[7:0], u[15:8]} : u, sos);
  endtask

  task automatic write_swap(input logic value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_swap(value);
  endtask

  task automatic send_string();
    int unsigned len;
    int unsigned kind;
    logic [15:0] u;
    logic        first;
    first = 1'b1;
    if ($urandom_range(3) == 0) begin
      push_unit(BOM_UNIT, 1'b1);
      first = 1'b0;
    end
    len = $urandom_range(10, 1);
    repeat (len) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        u = 16'($urandom_range(16'h007F, 16'h0000));
      end else if (kind < 45) begin
        u = 16'($urandom_range(16'h07FF, 16'h0080));
      end else if (kind < 65) begin
        u = 16'($urandom_range(16'hFFFF, 16'h0800));
        if (u >= 16'hD800 && u <= 16'hDFFF) u = u ^ 16'h4000;
      end else if (kind < 85) begin
        push_host(16'($urandom_range(16'hDBFF, 16'hD800)), first);
        first = 1'b0;
        u = 16'($urandom_range(16'hDFFF, 16'hDC00));
      end else if (kind < 90) begin
        u = 16'($urandom_range(16'hDFFF, 16'hDC00));
      end else if (kind < 95) begin
        push_host(16'($urandom_range(16'hDBFF, 16'hD800)), first);
        first = 1'b0;
        u = 16'($urandom());
      end else begin
        u = 16'($urandom());
      end
      push_host(u, first || ($urandom_range(29) == 0));
      first = 1'b0;
    end
  endtask

  initial begin
    int unsigned target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_swap(1'b0);
    push_unit(16'h0000, 1'b1);
    push_unit(16'h007F, 1'b0);
    push_unit(16'h0080, 1'b0);
    push_unit(16'h07FF, 1'b0);
    push_unit(16'h0800, 1'b0);
    push_unit(16'hFFFF, 1'b0);
    push_unit(16'hFEFF, 1'b1);
    push_unit(16'hFEFF, 1'b0);
    push_unit(16'hD800, 1'b0);
    push_unit(16'hDC00, 1'b0);
    push_unit(16'hDBFF, 1'b0);
    push_unit(16'hDFFF, 1'b0);
    push_unit(16'hD812, 1'b0);
    push_unit(16'h0041, 1'b0);
    push_unit(16'hDA00, 1'b0);
    push_unit(16'h1234, 1'b1);
    push_unit(16'hDC00, 1'b0);
    push_unit(16'hDFFF, 1'b0);
    push_unit(16'hDBFF, 1'b0);
    push_unit(16'hFEFF, 1'b1);

    write_swap(1'b1);
    push_unit(16'hFFFE, 1'b1);
    push_unit(16'hFEFF, 1'b1);
    push_unit(16'h00D8, 1'b0);
    push_unit(16'h00DC, 1'b0);
    push_unit(16'h8000, 1'b0);
    push_unit(16'hFF07, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      write_swap(p[0]);
      no_gaps = (p == 2);
      target = units_sent + PHASE_UNITS;
      while (units_sent < target) send_string();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_encoder_core.sv
tb/tb_u16u8_sb_pkg.sv
tb/tb_utf16_to_utf8_encoder_core.sv
